FILE: hw/rtl/symmetric_fir_lowpass_60tap_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric low-pass FIR core
// Shared shorthand for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_FIR_LOWPASS_60TAP_CORE_DEFINES_SVH
`define SYMMETRIC_FIR_LOWPASS_60TAP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SYMFIR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SYMFIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/symfir_pkg.sv
// ----------------------------------------------------------------------------
// symfir_pkg
// Widths, coefficient table and shared types of the symmetric FIR core.
// ----------------------------------------------------------------------------
`default_nettype none

package symfir_pkg;

   localparam int TAPS        = 60;
   localparam int HALF_TAPS   = TAPS / 2;
   localparam int CNT_W       = $clog2(TAPS);
   localparam int IDX_W       = $clog2(HALF_TAPS + 1);
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 18;
   localparam int PROD_W      = SAMPLE_W + 1 + COEF_W;
   localparam int ACC_W       = 41;
   localparam int OUT_W       = 18;
   localparam int ROUND_SHIFT = 20;
   localparam int OUT_MAX     = 131071;
   localparam int OUT_MIN     = -131072;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam logic [SAMPLE_W-1:0] RESET_OLDEST = 16'd24576;

   typedef logic [CNT_W-1:0] step_cnt_type;

   // Control that travels with each tap from the sequencer into the MAC.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } mac_ctrl_type;

   // Signed Q0.20 coefficients, first half of the symmetric response.
   localparam logic signed [COEF_W-1:0] COEF_TABLE [0:HALF_TAPS] = '{
      18'sd0,      18'sd293,    18'sd630,    18'sd1023,   18'sd1460,
      18'sd1887,   18'sd2216,   18'sd2323,   18'sd2067,   18'sd1322,
      18'sd0,      -18'sd1913,  -18'sd4329,  -18'sd7045,  -18'sd9741,
      -18'sd11996, -18'sd13306, -18'sd13181, -18'sd11136, -18'sd6805,
      18'sd0,      18'sd9270,   18'sd20751,  18'sd33953,  18'sd48172,
      18'sd62527,  18'sd76064,  18'sd87818,  18'sd96930,  18'sd102698,
      18'sd104669
   };

   // Coefficient for delay-line entry k (oldest is zero), mirrored about the center.
   function automatic logic signed [COEF_W-1:0] coef_for(input step_cnt_type k);
      step_cnt_type idx;
      idx = (k <= CNT_W'(HALF_TAPS)) ? k : (CNT_W'(TAPS) - k);
      return COEF_TABLE[idx[IDX_W-1:0]];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/symmetric_fir_lowpass_60tap_core.sv
// ----------------------------------------------------------------------------
// symmetric_fir_lowpass_60tap_core
// 60-tap symmetric low-pass FIR on unsigned Q2.14 voltage samples.
// ----------------------------------------------------------------------------
// The core filters one voltage sample per transfer and returns one filtered
// value per transfer. After the input transfer the chain of 60 delay-line
// cells shifts 61 times, one entry per cycle in front of a single shared
// multiplier. The first shift drops the oldest entry and takes in the new
// sample. The next 59 shifts bring the remaining taps to the multiplier. The
// last shift closes the rotation so the oldest entry sits in front again.
// The first and last entries seen in a pass meet the zero end coefficient
// and add nothing. The multiplier pipeline then drains, and the sum is
// rounded, saturated and loaded into the output register. A result that is
// still waiting in the output register when the next sum is ready holds the
// core until the result side takes it. The output lags the input by one
// sample because the sum is formed before the new sample enters the line.
// After reset the oldest entry holds 1.5 V and all others zero. A finished
// result waits in the output register while the next sample is already
// being accepted and filtered; new samples are taken only between passes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "symmetric_fir_lowpass_60tap_core_defines.svh"

module symmetric_fir_lowpass_60tap_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [symfir_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [15:0] sample
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic      [symfir_pkg::RSP_TDATA_W-1:0]     rsp_tdata   // [17:0] filtered, rest zero
);
   import symfir_pkg::*;

   // The rounded sum keeps the integer bits of the accumulator plus one carry bit.
   localparam int Q_W = ACC_W + 1 - ROUND_SHIFT;
   localparam logic signed [Q_W-1:0]   SAT_HI     = Q_W'(OUT_MAX);
   localparam logic signed [Q_W-1:0]   SAT_LO     = Q_W'(OUT_MIN);
   localparam logic signed [ACC_W:0]   ROUND_HALF = (ACC_W+1)'(1 << (ROUND_SHIFT - 1));
   // One shift more than there are taps: the pass ends with the line
   // advanced by exactly one sample.
   localparam step_cnt_type            LAST_STEP  = CNT_W'(TAPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FIN
   } state_type;

   state_type                state_ff;
   step_cnt_type             step_cnt_ff;
   logic [SAMPLE_W-1:0]      new_sample_ff;
   logic                     rsp_tvalid_ff;
   logic [OUT_W-1:0]         rsp_data_ff;
   logic [OUT_W-1:0]         rsp_data_in;

   logic [SAMPLE_W-1:0]      cell_q [TAPS];
   logic                     shift_en;
   logic [SAMPLE_W-1:0]      top_feed;
   mac_ctrl_type             mac_ctrl;
   logic signed [COEF_W-1:0] coef;
   logic signed [ACC_W-1:0]  mac_acc;
   logic                     mac_done;
   logic signed [ACC_W:0]    rnd_sum;
   logic signed [Q_W-1:0]    rnd_q;
   logic                     rsp_slot_free;
   logic                     rsp_load;

   // Accepting a new sample only needs the filter to be free; the output
   // register decouples the result side.
   assign req_tready    = (state_ff == ST_IDLE);
   assign rsp_slot_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load      = (state_ff == ST_FIN) && rsp_slot_free;

   // On the first step the oldest entry falls out (its coefficient is zero)
   // and the new sample enters at the top; the line then already holds its
   // next contents. The remaining 60 steps rotate it once all the way round,
   // so the oldest entry is back in front when the pass ends.
   assign shift_en = (state_ff == ST_RUN);
   assign top_feed = (step_cnt_ff == '0) ? new_sample_ff : cell_q[0];

   genvar gi;
   generate
      for (gi = 0; gi < TAPS; gi++) begin : g_chain
         if (gi == TAPS - 1) begin : g_top
            symfir_cell #(
               .RESET_VALUE (SAMPLE_W'(0))
            ) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .d_in     (top_feed),
               .q_out    (cell_q[gi])
            );
         end else begin : g_mid
            symfir_cell #(
               .RESET_VALUE ((gi == 0) ? RESET_OLDEST : SAMPLE_W'(0))
            ) u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .d_in     (cell_q[gi+1]),
               .q_out    (cell_q[gi])
            );
         end
      end
   endgenerate

   // The step count equals the original index of the entry now at the front.
   // On the last step the new sample is in front; its mirrored index is the
   // zero end coefficient, so it adds nothing.
   assign coef     = coef_for(step_cnt_ff);
   assign mac_ctrl = '{vld:   shift_en,
                       first: (step_cnt_ff == '0),
                       last:  (step_cnt_ff == LAST_STEP)};

   symfir_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (cell_q[0]),
      .coef   (coef),
      .acc    (mac_acc),
      .done   (mac_done)
   );

   // Round half up: add half an LSB, then an arithmetic shift floors the sum.
   // Out-of-range results clamp to the signed 18-bit limits.
   always_comb begin
      rnd_sum = {mac_acc[ACC_W-1], mac_acc} + ROUND_HALF;
      rnd_q   = $signed(rnd_sum[ACC_W:ROUND_SHIFT]);
      if (rnd_q > SAT_HI) begin
         rsp_data_in = SAT_HI[OUT_W-1:0];
      end else if (rnd_q < SAT_LO) begin
         rsp_data_in = SAT_LO[OUT_W-1:0];
      end else begin
         rsp_data_in = rnd_q[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_cnt_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // A new result may replace the one leaving in the same cycle.
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff    <= ST_RUN;
                  step_cnt_ff <= '0;
               end
            end
            ST_RUN: begin
               if (step_cnt_ff == LAST_STEP) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  step_cnt_ff <= step_cnt_ff + CNT_W'(1);
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // Hold the finished sum until the output register is free.
               if (rsp_slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         new_sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-OUT_W)'(0), rsp_data_ff};

   `SYMFIR_ASSERT_NEXT(a_accept_starts_pass, clock, reset, req_tvalid && req_tready, state_ff == ST_RUN && step_cnt_ff == '0, "accepted transfer did not start a pass at the first tap")
   `SYMFIR_ASSERT_NEXT(a_pass_ends_after_last_tap, clock, reset, state_ff == ST_RUN && step_cnt_ff == LAST_STEP, state_ff == ST_DRAIN, "pass did not stop after the last tap")
   `SYMFIR_ASSERT_SAME(a_mac_done_while_draining, clock, reset, mac_done, state_ff == ST_DRAIN, "accumulator finished outside the drain phase")

endmodule

`default_nettype wire

FILE: hw/rtl/symfir_cell.sv
// ----------------------------------------------------------------------------
// symfir_cell
// One delay-line entry; takes its neighbor's sample on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module symfir_cell #(
   parameter logic [symfir_pkg::SAMPLE_W-1:0] RESET_VALUE = 16'd0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              shift_en,
   input  wire logic [symfir_pkg::SAMPLE_W-1:0]   d_in,
   output logic      [symfir_pkg::SAMPLE_W-1:0]   q_out
);
   import symfir_pkg::*;

   logic [SAMPLE_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= RESET_VALUE;
      end else if (shift_en) begin
         sample_ff <= d_in;
      end
   end

   assign q_out = sample_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/symfir_mac.sv
// ----------------------------------------------------------------------------
// symfir_mac
// Two-stage multiply-accumulate over the taps streamed out of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module symfir_mac (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire symfir_pkg::mac_ctrl_type              ctrl,
   input  wire logic        [symfir_pkg::SAMPLE_W-1:0] sample,
   input  wire logic signed [symfir_pkg::COEF_W-1:0]   coef,
   output logic signed      [symfir_pkg::ACC_W-1:0]    acc,
   output logic                                       done
);
   import symfir_pkg::*;

   mac_ctrl_type              ctrl_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic                      done_ff;

   // Stage one: product of the sample, taken as non-negative, and the coefficient.
   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, sample}) * coef;
   end

   // The first tap restarts the sum.
   always_comb begin
      acc_in = (ctrl_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         done_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         ctrl_ff <= ctrl;
         done_ff <= ctrl_ff.vld && ctrl_ff.last;
         if (ctrl_ff.vld) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

FILE: tb/tb_symmetric_fir_lowpass_60tap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_fir_lowpass_60tap_core
// Self-checking bench for the 60-tap symmetric low-pass voltage filter.
// ----------------------------------------------------------------------------
// Voltage samples go in over the request stream and filtered values come back
// over the response stream. A behavioral copy of the filter runs next to the
// core and predicts every filtered value. Each returned value is compared with
// the oldest prediction. A short table of directed samples comes first, then
// 1500 random samples shaped as noise, flat levels, full-scale steps, square
// waves, ramps and values near the idle level. Both sides of the core idle at
// random. Once in the run the response side holds off for a long stretch so
// that the core fills up and stalls its input.
// ----------------------------------------------------------------------------

module tb_symmetric_fir_lowpass_60tap_core;

   localparam int CLK_HALF_PERIOD  = 2;
   localparam int RESET_CYCLES     = 6;
   localparam int RANDOM_SAMPLES   = 1500;
   localparam int DRAIN_CYCLES     = 200;
   localparam int LONG_HOLD_AFTER  = 300;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int DIRECTED_ROWS    = 22;
   localparam int TAP_COUNT        = symfir_pkg::TAPS;
   localparam int CENTER_TAP       = TAP_COUNT / 2;
   localparam int ROUND_HALF       = 1 << 19;
   localparam int FILTERED_MAX     = 131071;
   localparam int FILTERED_MIN     = -131072;
   localparam logic [15:0] IDLE_VOLTS   = 16'd24576;  // 1.5 V, the reset level
   localparam logic [15:0] FULL_SCALE   = 16'hFFFF;

   // Shapes of the random sample segments.
   typedef enum int {
      SHAPE_NOISE,
      SHAPE_LEVEL,
      SHAPE_EXTREMES,
      SHAPE_SQUARE,
      SHAPE_NEAR_IDLE,
      SHAPE_RAMP
   } shape_kind_type;

   // One row of the directed table. Where known is set, the filtered value
   // is written into the row; otherwise the behavioral filter supplies it.
   typedef struct packed {
      logic [15:0]        sample;
      logic               known;
      logic signed [17:0] filtered;
   } directed_row_type;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [symfir_pkg::REQ_TDATA_W-1:0]   req_tdata  = '0;   // [15:0] sample
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [symfir_pkg::RSP_TDATA_W-1:0]   rsp_tdata;         // [17:0] filtered, rest zero

   // Behavioral copy of the filter: delay line (entry 0 the oldest) and the
   // first half of the symmetric Q0.20 coefficient set.
   logic [15:0] volt_line [0:TAP_COUNT-1];
   int lowpass_coef [0:CENTER_TAP] = '{
      0, 293, 630, 1023, 1460, 1887, 2216, 2323, 2067, 1322,
      0, -1913, -4329, -7045, -9741, -11996, -13306, -13181, -11136, -6805,
      0, 9270, 20751, 33953, 48172, 62527, 76064, 87818, 96930, 102698,
      104669
   };

   // Filtered values still owed by the core, oldest first.
   logic signed [17:0] expected_filtered [$];

   int samples_sent        = 0;
   int results_seen        = 0;
   int mismatches          = 0;
   int input_stall_cycles  = 0;
   int filtered_peak       = FILTERED_MIN;
   int filtered_trough     = FILTERED_MAX;
   int got_value;
   logic signed [17:0] want_value;

   // The first three rows start from the reset state. The oldest entry sits
   // on the zero coefficient, so the first value is zero. The third value is
   // 755*630 + 166*293 = 2^19 exactly in Q2.34, a tie that must round up.
   directed_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{16'd755,   1'b1, 18'sd0},
      '{16'd166,   1'b1, 18'sd0},
      '{16'd0,     1'b1, 18'sd1},
      '{16'hFFFF,  1'b0, 18'sd0},
      '{16'hFFFF,  1'b0, 18'sd0},
      '{16'h0000,  1'b0, 18'sd0},
      '{16'hAAAA,  1'b0, 18'sd0},
      '{16'h5555,  1'b0, 18'sd0},
      '{16'h8000,  1'b0, 18'sd0},
      '{16'h7FFF,  1'b0, 18'sd0},
      '{16'h0001,  1'b0, 18'sd0},
      '{16'hFFFE,  1'b0, 18'sd0},
      '{16'hFFFF,  1'b0, 18'sd0},
      '{16'hFFFF,  1'b0, 18'sd0},
      '{16'hFFFF,  1'b0, 18'sd0},
      '{16'hFFFF,  1'b0, 18'sd0},
      '{16'h0000,  1'b0, 18'sd0},
      '{16'h0000,  1'b0, 18'sd0},
      '{16'h0000,  1'b0, 18'sd0},
      '{16'd24576, 1'b0, 18'sd0},
      '{16'd24576, 1'b0, 18'sd0},
      '{16'hFFFF,  1'b0, 18'sd0}
   };

   symmetric_fir_lowpass_60tap_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #CLK_HALF_PERIOD clock = ~clock;
   end

   // Forms the filtered value for the current delay line, then shifts the new
   // sample in. The sum is exact, rounded half up by a floor shift and then
   // clamped to the signed 18-bit range.
   function automatic logic signed [17:0] filter_sample(input logic [15:0] sample);
      longint acc;
      longint tap_volts;
      longint rounded;
      int     k;
      int     coef_idx;
      acc = 0;
      for (k = 0; k < TAP_COUNT; k++) begin
         coef_idx  = (k <= CENTER_TAP) ? k : TAP_COUNT - k;
         tap_volts = volt_line[k];
         acc       = acc + tap_volts * lowpass_coef[coef_idx];
      end
      for (k = 0; k < TAP_COUNT - 1; k++) begin
         volt_line[k] = volt_line[k + 1];
      end
      volt_line[TAP_COUNT - 1] = sample;
      rounded = (acc + ROUND_HALF) >>> 20;
      if (rounded > FILTERED_MAX) begin
         rounded = FILTERED_MAX;
      end
      if (rounded < FILTERED_MIN) begin
         rounded = FILTERED_MIN;
      end
      return rounded[17:0];
   endfunction

   // Idle cycles before the next sample. Every 200 samples a stretch of 40
   // goes back to back; otherwise gaps are mostly short, some cover a large
   // part of the filter pass, and a few outlast it.
   function automatic int sender_gap(input int n);
      int pick;
      pick = $urandom_range(0, 99);
      if ((n % 200) < 40) begin
         return 0;
      end
      if (pick < 40) begin
         return 0;
      end
      if (pick < 75) begin
         return $urandom_range(1, 8);
      end
      if (pick < 93) begin
         return $urandom_range(9, 70);
      end
      return $urandom_range(100, 200);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t ns, result %0d: %s, got %0d, expected %0d",
               $time, results_seen, what, got, want);
      mismatches++;
   endtask

   // Offers one sample and waits for its transfer. A valid that stays high
   // for a back-to-back sample is not lowered in between. The prediction is
   // queued at the edge that moves the sample.
   task automatic offer_sample(input logic [15:0] sample, input int idle_cycles,
                               input logic known, input logic signed [17:0] known_value);
      logic signed [17:0] predicted;
      if (idle_cycles > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         repeat (idle_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      predicted = filter_sample(sample);
      expected_filtered.push_back(known ? known_value : predicted);
      samples_sent++;
   endtask

   // Response checker: every transfer on the response side is matched with
   // the oldest outstanding prediction. The bits above the filtered field
   // must stay zero.
   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) begin
         input_stall_cycles++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_value = $signed(rsp_tdata[17:0]);
         if (expected_filtered.size() == 0) begin
            flag_mismatch("filtered value with nothing outstanding", got_value, 0);
         end else begin
            want_value = expected_filtered.pop_front();
            if (got_value != want_value) begin
               flag_mismatch("filtered value", got_value, want_value);
            end
            if (rsp_tdata[symfir_pkg::RSP_TDATA_W-1:18] != '0) begin
               flag_mismatch("padding above filtered",
                             int'(rsp_tdata[symfir_pkg::RSP_TDATA_W-1:18]), 0);
            end
         end
         if (got_value > filtered_peak) begin
            filtered_peak = got_value;
         end
         if (got_value < filtered_trough) begin
            filtered_trough = got_value;
         end
         results_seen++;
      end
   end

   // Response side: ready in random runs with random gaps. Once enough
   // results have come back it holds off for a long stretch, long enough for
   // the core to finish the waiting result, filter the next one and refuse
   // further samples.
   initial begin
      bit long_hold_done;
      int pick;
      int stall;
      long_hold_done = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            stall = 0;
         end else if (pick < 80) begin
            stall = $urandom_range(1, 4);
         end else if (pick < 95) begin
            stall = $urandom_range(5, 70);
         end else begin
            stall = $urandom_range(100, 250);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Main sequence: reset, directed table, shaped random segments, drain.
   initial begin
      int             row;
      int             random_sent;
      int             seg_len;
      int             seg_pos;
      int             period;
      shape_kind_type shape;
      logic [15:0]    level;
      logic [15:0]    sample;

      for (row = 0; row < TAP_COUNT; row++) begin
         volt_line[row] = '0;
      end
      volt_line[0] = IDLE_VOLTS;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         offer_sample(directed_rows[row].sample, sender_gap(row + 100),
                      directed_rows[row].known, directed_rows[row].filtered);
      end

      // Random segments of a few to about ninety samples. Flat runs longer than
      // the 60 taps settle the output at a steady level, square waves drive the
      // negative lobes of the response.
      random_sent = 0;
      while (random_sent < RANDOM_SAMPLES) begin
         shape   = shape_kind_type'($urandom_range(SHAPE_NOISE, SHAPE_RAMP));
         seg_len = $urandom_range(4, 90);
         level   = 16'($urandom);
         period  = $urandom_range(2, 40);
         for (seg_pos = 0; seg_pos < seg_len && random_sent < RANDOM_SAMPLES;
              seg_pos++) begin
            case (shape)
               SHAPE_NOISE: begin
                  sample = 16'($urandom);
               end
               SHAPE_LEVEL: begin
                  sample = level;
               end
               SHAPE_EXTREMES: begin
                  sample = ($urandom_range(0, 3) != 0) ? FULL_SCALE : 16'h0000;
               end
               SHAPE_SQUARE: begin
                  sample = ((seg_pos / period) % 2 != 0) ? FULL_SCALE : 16'h0000;
               end
               SHAPE_NEAR_IDLE: begin
                  sample = IDLE_VOLTS + 16'($urandom_range(0, 511)) - 16'd256;
               end
               default: begin
                  sample = level + 16'(seg_pos * period * 37);
               end
            endcase
            offer_sample(sample, sender_gap(random_sent), 1'b0, 18'sd0);
            random_sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d samples (%0d from the directed table) and %0d filtered values.",
               samples_sent, DIRECTED_ROWS, results_seen);
      $display("Filtered output spanned %0d to %0d; the input was held off for %0d cycles.",
               filtered_trough, filtered_peak, input_stall_cycles);
      if (mismatches == 0) begin
         $display("symmetric_fir_lowpass_60tap_core verification clean");
      end else begin
         $display("symmetric_fir_lowpass_60tap_core verification failed");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a quarter of this time.
   initial begin
      #20_000_000;
      $display("Timeout with %0d filtered values still outstanding.",
               expected_filtered.size());
      $display("symmetric_fir_lowpass_60tap_core verification failed");
      $finish;
   end

endmodule

FILE: symmetric_fir_lowpass_60tap_core.f
+incdir+hw/rtl
hw/rtl/symfir_pkg.sv
hw/rtl/symfir_cell.sv
hw/rtl/symfir_mac.sv
hw/rtl/symmetric_fir_lowpass_60tap_core.sv
tb/tb_symmetric_fir_lowpass_60tap_core.sv
